// ----- hw/rtl/sac_pkg.sv -----
// Shared types, constants and a helper function for the shortest-arc quaternion block.
package sac_pkg;

  localparam int CW          = 16;
  localparam int FB          = 14;
  localparam int PROD_W      = 2 * CW;
  localparam int DOT_W       = PROD_W + 2;
  localparam int MAG_W       = PROD_W;
  localparam int TOP_W       = $clog2(MAG_W);
  localparam int NORM_TOP    = 29;
  localparam int NORM_W      = NORM_TOP + 1;
  localparam int SQ_W        = 2 * NORM_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int SQ_N        = SUM_W / 2;
  localparam int LEN_W       = NORM_W + 1;
  localparam int NUM_W       = LEN_W + FB;
  localparam int Q_W         = FB + 1;
  localparam int DIV_N       = Q_W;
  localparam int LIM_W       = 15;
  localparam int ADDR_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LIM_W-1:0] NEAR_ONE_RESET  = 15'd16383;
  localparam logic [LIM_W-1:0] SHORT_LEN_RESET = 15'd1;

  // Register index, taken from paddr[2].
  localparam logic REG_NEAR_ONE  = 1'b0;
  localparam logic REG_SHORT_LEN = 1'b1;

  typedef logic signed [CW-1:0] comp_t;

  typedef enum logic [1:0] {
    KIND_GENERAL  = 2'd0,
    KIND_IDENT    = 2'd1,
    KIND_OPPOSITE = 2'd2
  } kind_t;

  typedef struct packed {
    comp_t from_x;
    comp_t from_y;
    comp_t from_z;
    comp_t to_x;
    comp_t to_y;
    comp_t to_z;
  } vec_t;

  typedef struct packed {
    comp_t      rot_x;
    comp_t      rot_y;
    comp_t      rot_z;
    comp_t      rot_w;
    logic [1:0] case_taken;
  } rot_t;

  typedef struct packed {
    logic [LIM_W-1:0] near_one_limit;
    logic [LIM_W-1:0] short_length_limit;
  } cfg_t;

  // Classified request: four component magnitudes with their signs.
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    kind_t                 kind;
  } item_t;

  // Scaled components carried alongside the square root and divide stages.
  typedef struct packed {
    logic [3:0][NORM_W-1:0] m;
    logic [3:0]             neg;
    kind_t                  kind;
    logic                   zero;
  } side_t;

  // Restores the sign and saturates a normalized magnitude.
  function automatic comp_t to_field(input logic [Q_W-1:0] v, input logic neg);
    logic [63:0] vx;
    logic [63:0] cap;
    logic [63:0] r;
    vx  = 64'(v);
    cap = 64'(1) << (CW - 1);
    if (!neg) begin
      if (vx > cap - 64'(1)) vx = cap - 64'(1);
      r = vx;
    end else begin
      if (vx > cap) vx = cap;
      r = -vx;
    end
    return r[CW-1:0];
  endfunction

endpackage

// ----- hw/rtl/sac_front.sv -----
// Front end: products, dot and cross sums, and classification of each request.
module sac_front (
  input  logic          clk,
  input  logic          rst,
  input  sac_pkg::cfg_t cfg,
  input  sac_pkg::vec_t vec,
  input  logic          vec_valid,
  output logic          vec_ready,
  output sac_pkg::item_t item,
  output logic          item_push,
  input  logic          queue_full
);
  import sac_pkg::*;

  localparam logic signed [DOT_W-1:0] One = DOT_W'(1) << (2 * FB);

  logic                     f1_valid;
  logic signed [PROD_W-1:0] p00, p11, p22, p12, p21, p20, p02, p01, p10, s11, s22;
  comp_t                    a0, a1, a2;
  logic                     fadv;

  logic signed [DOT_W-1:0]  dot, lim, cx, cy, cz, qw;
  logic [PROD_W:0]          ysq;
  logic [2*LIM_W-1:0]       sll_sq;
  logic                     opposite, ident, short_axis;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  assign fadv      = !f1_valid || !queue_full;
  assign vec_ready = fadv;
  assign item_push = f1_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (fadv) begin
      f1_valid <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      p00 <= $signed(vec.from_x) * $signed(vec.to_x);
      p11 <= $signed(vec.from_y) * $signed(vec.to_y);
      p22 <= $signed(vec.from_z) * $signed(vec.to_z);
      p12 <= $signed(vec.from_y) * $signed(vec.to_z);
      p21 <= $signed(vec.from_z) * $signed(vec.to_y);
      p20 <= $signed(vec.from_z) * $signed(vec.to_x);
      p02 <= $signed(vec.from_x) * $signed(vec.to_z);
      p01 <= $signed(vec.from_x) * $signed(vec.to_y);
      p10 <= $signed(vec.from_y) * $signed(vec.to_x);
      s11 <= $signed(vec.from_y) * $signed(vec.from_y);
      s22 <= $signed(vec.from_z) * $signed(vec.from_z);
      a0  <= vec.from_x;
      a1  <= vec.from_y;
      a2  <= vec.from_z;
    end
  end

  always_comb begin
    dot        = DOT_W'(p00) + DOT_W'(p11) + DOT_W'(p22);
    lim        = DOT_W'(cfg.near_one_limit) << FB;
    cx         = DOT_W'(p12) - DOT_W'(p21);
    cy         = DOT_W'(p20) - DOT_W'(p02);
    cz         = DOT_W'(p01) - DOT_W'(p10);
    qw         = dot + One;
    ysq        = (PROD_W+1)'(unsigned'(s11)) + (PROD_W+1)'(unsigned'(s22));
    sll_sq     = (2*LIM_W)'(cfg.short_length_limit) * (2*LIM_W)'(cfg.short_length_limit);
    opposite   = dot < -lim;
    ident      = dot > lim;
    short_axis = ysq < (PROD_W+1)'(sll_sq);

    item.mag  = '0;
    item.neg  = '0;
    item.kind = KIND_GENERAL;
    if (opposite) begin
      item.kind = KIND_OPPOSITE;
      if (short_axis) begin
        item.mag[0] = mag_of(DOT_W'(a2));
        item.neg[0] = a2 > 0;
        item.mag[2] = mag_of(DOT_W'(a0));
        item.neg[2] = a0 < 0;
      end else begin
        item.mag[1] = mag_of(DOT_W'(a2));
        item.neg[1] = a2 < 0;
        item.mag[2] = mag_of(DOT_W'(a1));
        item.neg[2] = a1 > 0;
      end
    end else if (ident) begin
      item.kind = KIND_IDENT;
    end else begin
      item.mag[0] = mag_of(cx);
      item.neg[0] = cx < 0;
      item.mag[1] = mag_of(cy);
      item.neg[1] = cy < 0;
      item.mag[2] = mag_of(cz);
      item.neg[2] = cz < 0;
      item.mag[3] = mag_of(qw);
      item.neg[3] = qw < 0;
    end
  end

endmodule

// ----- hw/rtl/sac_queue.sv -----
// Small queue of classified requests between the front end and the back end.
module sac_queue (
  input  logic           clk,
  input  logic           rst,
  input  sac_pkg::item_t wr_item,
  input  logic           push,
  output logic           full,
  output sac_pkg::item_t rd_item,
  output logic           rd_valid,
  input  logic           pop
);
  import sac_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sac_back.sv -----
// Back end: scaling, square root and divide pipeline that normalizes each request.
module sac_back (
  input  logic           clk,
  input  logic           rst,
  input  sac_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_pop,
  output sac_pkg::rot_t  rot,
  output logic           rot_valid,
  input  logic           rot_ready
);
  import sac_pkg::*;

  logic adv;

  assign adv      = !rot_valid || rot_ready;
  assign item_pop = adv && item_valid;

  // Leading-one search over the four magnitudes.
  logic [MAG_W-1:0] all_bits;
  logic [TOP_W-1:0] top_c;

  always_comb begin
    all_bits = item.mag[0] | item.mag[1] | item.mag[2] | item.mag[3];
    top_c    = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (all_bits[b]) top_c = TOP_W'(b);
    end
  end

  logic             v1;
  item_t            it1;
  logic [TOP_W-1:0] top1;
  logic             zero1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1   <= item;
      top1  <= top_c;
      zero1 <= all_bits == '0;
    end
  end

  // Common shift that brings the largest magnitude to bit NORM_TOP.
  logic  v2;
  side_t side2;
  logic [MAG_W+NORM_TOP-1:0] wide [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {it1.mag[i], NORM_TOP'(0)} >> top1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) side2.m[i] <= wide[i][NORM_W-1:0];
      side2.neg  <= it1.neg;
      side2.kind <= it1.kind;
      side2.zero <= zero1;
    end
  end

  logic            v3;
  side_t           side3;
  logic [SQ_W-1:0] sq3 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3 <= side2;
      for (int i = 0; i < 4; i++) sq3[i] <= SQ_W'(side2.m[i]) * SQ_W'(side2.m[i]);
    end
  end

  // Square root pipeline, one result bit per stage. Index 0 holds the sum.
  logic             sv    [SQ_N+1];
  side_t            sside [SQ_N+1];
  logic [SUM_W-1:0] srem  [SQ_N+1];
  logic [SUM_W-1:0] sres  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sside[0] <= side3;
      srem[0]  <= SUM_W'(sq3[0]) + SUM_W'(sq3[1]) + SUM_W'(sq3[2]) + SUM_W'(sq3[3]);
      sres[0]  <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [SUM_W:0] BitK = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W:0] trial;
    logic           take;

    assign trial = (SUM_W+1)'(sres[k]) + BitK;
    assign take  = (SUM_W+1)'(srem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sside[k+1] <= sside[k];
        if (take) begin
          srem[k+1] <= srem[k] - trial[SUM_W-1:0];
          sres[k+1] <= (sres[k] >> 1) + BitK[SUM_W-1:0];
        end else begin
          srem[k+1] <= srem[k];
          sres[k+1] <= sres[k] >> 1;
        end
      end
    end
  end

  // Restoring divide, one quotient bit per stage. Index 0 holds the rounded numerators.
  logic [LEN_W-1:0] len_c;
  assign len_c = sres[SQ_N][LEN_W-1:0];

  logic                  dv    [DIV_N+1];
  side_t                 dside [DIV_N+1];
  logic [LEN_W-1:0]      dlen  [DIV_N+1];
  logic [3:0][NUM_W-1:0] drem  [DIV_N+1];
  logic [3:0][Q_W-1:0]   dq    [DIV_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= sside[SQ_N];
      dlen[0]  <= len_c;
      dq[0]    <= '0;
      for (int i = 0; i < 4; i++) begin
        drem[0][i] <= (NUM_W'(sside[SQ_N].m[i]) << FB) + NUM_W'(len_c >> 1);
      end
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int Sh = FB - k;
    logic [NUM_W-1:0] dvs;

    assign dvs = NUM_W'(dlen[k]) << Sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dside[k+1] <= dside[k];
        dlen[k+1]  <= dlen[k];
        for (int i = 0; i < 4; i++) begin
          if (drem[k][i] >= dvs) begin
            drem[k+1][i]   <= drem[k][i] - dvs;
            dq[k+1][i]     <= dq[k][i] | (Q_W'(1) << Sh);
          end else begin
            drem[k+1][i]   <= drem[k][i];
            dq[k+1][i]     <= dq[k][i];
          end
        end
      end
    end
  end

  // Result register; it also parts the back end from the consumer.
  rot_t  rot_c;
  side_t fin;

  always_comb begin
    fin              = dside[DIV_N];
    rot_c.case_taken = fin.kind;
    if (fin.kind == KIND_IDENT) begin
      rot_c.rot_x = '0;
      rot_c.rot_y = '0;
      rot_c.rot_z = '0;
      rot_c.rot_w = to_field(Q_W'(1) << FB, 1'b0);
    end else if (fin.zero) begin
      rot_c.rot_x = '0;
      rot_c.rot_y = '0;
      rot_c.rot_z = '0;
      rot_c.rot_w = '0;
    end else begin
      rot_c.rot_x = to_field(dq[DIV_N][0], fin.neg[0]);
      rot_c.rot_y = to_field(dq[DIV_N][1], fin.neg[1]);
      rot_c.rot_z = to_field(dq[DIV_N][2], fin.neg[2]);
      rot_c.rot_w = to_field(dq[DIV_N][3], fin.neg[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (adv) begin
      rot_valid <= dv[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot <= rot_c;
    end
  end

endmodule

// ----- hw/rtl/shortest_arc_quaternion.sv -----
// Throughput: one request per cycle while rot_ready does not stall the back end; the square
// root (31 stages) and divide (15 stages) pipelines each take a new operand every such cycle.
// The front end stalls only when its four-entry queue is full; the back end only on rot_ready.
// Reset (rst, synchronous) empties every stage and the queue and loads the register defaults.
module shortest_arc_quaternion (
  input  logic                       clk,
  input  logic                       rst,
  input  sac_pkg::vec_t              vec,
  input  logic                       vec_valid,
  output logic                       vec_ready,
  output sac_pkg::rot_t              rot,
  output logic                       rot_valid,
  input  logic                       rot_ready,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sac_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sac_pkg::*;

  // Configuration registers. Writes are expected only while the block is idle,
  // so the front end may read them without any shadowing.
  cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_one_limit     <= NEAR_ONE_RESET;
      cfg.short_length_limit <= SHORT_LEN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NEAR_ONE:  cfg.near_one_limit     <= pwdata[LIM_W-1:0];
        REG_SHORT_LEN: cfg.short_length_limit <= pwdata[LIM_W-1:0];
        default:       cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NEAR_ONE:  prdata = 32'(cfg.near_one_limit);
      REG_SHORT_LEN: prdata = 32'(cfg.short_length_limit);
      default:       prdata = '0;
    endcase
  end

  // The front end forms the dot and cross products of each request and decides
  // whether it is a general, nearly identical or nearly opposite case. It hands
  // the four unnormalized quaternion components to the queue.
  item_t push_item, head_item;
  logic  push, queue_full, head_valid, pop;

  sac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .vec        (vec),
    .vec_valid  (vec_valid),
    .vec_ready  (vec_ready),
    .item       (push_item),
    .item_push  (push),
    .queue_full (queue_full)
  );

  // The four-entry queue lets the front end keep accepting requests while
  // the back end is held by the consumer.
  sac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (push_item),
    .push     (push),
    .full     (queue_full),
    .rd_item  (head_item),
    .rd_valid (head_valid),
    .pop      (pop)
  );

  // The back end scales, takes the length by a pipelined square root, divides
  // each component by it with rounding and saturates the result into the
  // output register.
  sac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (head_item),
    .item_valid (head_valid),
    .item_pop   (pop),
    .rot        (rot),
    .rot_valid  (rot_valid),
    .rot_ready  (rot_ready)
  );

endmodule
